>>> design/box_blur_rgba_defines.svh
// Assertion macros shared by the box blur RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BOX_BLUR_RGBA_DEFINES_SVH
`define BOX_BLUR_RGBA_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BBR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("box blur check failed");

// Consequent must hold in the same cycle as the antecedent.
`define BBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur check failed");

// Consequent must hold in the cycle after the antecedent.
`define BBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur check failed");

`endif

>>> design/bbr_pkg.sv
// Shared types and constants of the box blur block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package bbr_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int PIX_W       = CH_W * NUM_CH;
    localparam int STEP_BUDGET = 8;
    localparam int BUDGET_W    = 4;
    localparam int MAX_ROWS    = 1024;
    localparam int ROW_W       = 10;
    localparam int HGT_W       = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int RAD_W       = 3;
    localparam int AREA_W      = 8;
    // Largest window is 15x15 pixels of value 255.
    localparam int SUM_W       = 16;
    localparam int POS_W       = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_RUN
    } bbr_state_t;

endpackage

`default_nettype wire

>>> design/bbr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 15360
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/bbr_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the top level for the window means.
`timescale 1ns / 1ps
`default_nettype none

module bbr_div #(
    parameter int N_W = 16,
    parameter int D_W = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic      [N_W-1:0] quotient,
    output logic                done
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     rem_shift;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg, quo_reg[N_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = D_W'(rem_shift - {1'b0, dvs_reg});
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> design/box_blur_rgba.sv
// Top level of the streaming RGBA box blur: sequencer, line store, dividers.
// Depends on bbr_pkg, bbr_ram, bbr_div and box_blur_rgba_defines.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | action, in_red, in_green, in_blue, in_alpha
//  out     | out_valid/out_ready  | out_x, out_y, out_red..out_alpha,
//          |                      | frame_done, last
//
// After an item is accepted, the sequencer spends per result: one check,
// one line store read per window tap, one read drain, one divider start and
// the run of the four per-channel restoring dividers.
// Up to 8 results leave per item; a finished result waits in an output register.
// Reset clears control state only; the line store needs no clearing pass.
// A stalled output holds the sequencer once the next result is computed.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_rgba_defines.svh"

module box_blur_rgba #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             action,
    input  wire logic [bbr_pkg::CH_W-1:0]         in_red,
    input  wire logic [bbr_pkg::CH_W-1:0]         in_green,
    input  wire logic [bbr_pkg::CH_W-1:0]         in_blue,
    input  wire logic [bbr_pkg::CH_W-1:0]         in_alpha,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [bbr_pkg::POS_W-1:0]        out_x,
    output logic      [bbr_pkg::POS_W-1:0]        out_y,
    output logic      [bbr_pkg::CH_W-1:0]         out_red,
    output logic      [bbr_pkg::CH_W-1:0]         out_green,
    output logic      [bbr_pkg::CH_W-1:0]         out_blue,
    output logic      [bbr_pkg::CH_W-1:0]         out_alpha,
    output logic                                  frame_done,
    output logic                                  last
);

    import bbr_pkg::*;

    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int RING_W = $clog2(RING);
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WX_W   = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    function automatic logic [AW-1:0] addr_of(input logic [RING_W-1:0] rg,
                                              input logic [CW-1:0] c);
        return AW'(rg) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] rg);
        return (rg == RING_W'(RING - 1)) ? '0 : rg + 1'b1;
    endfunction

    bbr_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] fw_reg, fw_next;
    logic [CFG_DATA_W-1:0] fh_reg, fh_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;

    logic [CW-1:0]     in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [RING_W-1:0] in_ring_reg, in_ring_next;
    logic              complete_reg, complete_next;
    logic [CW-1:0]     emit_col_reg, emit_col_next;
    logic [ROW_W-1:0]  emit_row_reg, emit_row_next;
    logic [RING_W-1:0] emit_ring_reg, emit_ring_next;
    logic [BUDGET_W-1:0] n_reg, n_next;

    logic [CW-1:0]     xx_reg, xx_next;
    logic [CW-1:0]     xx0_reg, xx0_next;
    logic [RING_W-1:0] yring_reg, yring_next;
    logic [RING_W-1:0] dx_reg, dx_next;
    logic [RING_W-1:0] dy_reg, dy_next;
    logic              rd_v_reg, rd_v_next;
    logic [SUM_W-1:0]  acc_reg [NUM_CH];
    logic [SUM_W-1:0]  acc_next [NUM_CH];
    logic              fd_reg, fd_next;

    logic              pend_v_reg, pend_v_next;
    logic [POS_W-1:0]  pend_x_reg, pend_x_next;
    logic [POS_W-1:0]  pend_y_reg, pend_y_next;
    logic [CH_W-1:0]   pend_q_reg [NUM_CH];
    logic [CH_W-1:0]   pend_q_next [NUM_CH];
    logic              pend_fd_reg, pend_fd_next;

    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_x_reg, out_x_next;
    logic [POS_W-1:0]  out_y_reg, out_y_next;
    logic [CH_W-1:0]   out_q_reg [NUM_CH];
    logic [CH_W-1:0]   out_q_next [NUM_CH];
    logic              out_fd_reg, out_fd_next;
    logic              out_last_reg, out_last_next;

    // Effective configuration.
    logic [WX_W-1:0]   fw_x;
    logic [CW:0]       w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [RAD_W-1:0]  r_eff;
    logic [RING_W-1:0] r2;
    logic [3:0]        side;
    logic [AREA_W-1:0] area;

    logic [CW:0]       needx_raw, needx, wm1;
    logic [HGT_W-1:0]  needy_raw, needy, hm1;
    logic              win_ready, can_emit, out_free;
    logic [CW+1:0]     tx;
    logic [HGT_W:0]    ty;
    logic              x_move, y_move;
    logic [RING_W:0]   ring_back;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    logic              push, push_last, cfg_fire, in_fire;
    logic              div_start;
    logic [SUM_W-1:0]  div_q [NUM_CH];
    logic [NUM_CH-1:0] div_done;

    assign fw_x  = WX_W'(fw_reg);
    assign w_eff = (fw_reg == '0) ? (CW+1)'(1) :
                   (fw_x > WX_W'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(fw_x);
    assign h_eff = (fh_reg == '0) ? HGT_W'(1) :
                   (fh_reg > HGT_W'(MAX_ROWS)) ? HGT_W'(MAX_ROWS) : fh_reg;
    assign r_eff = (32'(rad_reg) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_reg;
    assign r2    = RING_W'({r_eff, 1'b0});
    assign side  = {r_eff, 1'b1};
    assign area  = AREA_W'(side * side);

    // An output is ready once the pixel at the bottom right of its window is in.
    assign wm1       = w_eff - 1'b1;
    assign hm1       = h_eff - 1'b1;
    assign needx_raw = (CW+1)'(emit_col_reg) + (CW+1)'(r_eff);
    assign needx     = (needx_raw > wm1) ? wm1 : needx_raw;
    assign needy_raw = HGT_W'(emit_row_reg) + HGT_W'(r_eff);
    assign needy     = (needy_raw > hm1) ? hm1 : needy_raw;
    assign win_ready = complete_reg || (needy < HGT_W'(in_row_reg)) ||
                       ((needy == HGT_W'(in_row_reg)) && (needx < (CW+1)'(in_col_reg)));
    assign can_emit  = (n_reg < BUDGET_W'(STEP_BUDGET)) && win_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Clamped window walk: the coordinate advances only while the raw
    // position of the next tap lies inside the frame past its first entry.
    assign tx     = (CW+2)'(emit_col_reg) + (CW+2)'(dx_reg) + 1'b1;
    assign x_move = (tx > (CW+2)'(r_eff)) && (tx < (CW+2)'(w_eff) + (CW+2)'(r_eff));
    assign ty     = (HGT_W+1)'(emit_row_reg) + (HGT_W+1)'(dy_reg) + 1'b1;
    assign y_move = (ty > (HGT_W+1)'(r_eff)) &&
                    (ty < (HGT_W+1)'(h_eff) + (HGT_W+1)'(r_eff));
    assign ring_back = ((RING_W+1)'(emit_ring_reg) >= (RING_W+1)'(r_eff)) ?
                       (RING_W+1)'(emit_ring_reg) - (RING_W+1)'(r_eff) :
                       (RING_W+1)'(emit_ring_reg) + (RING_W+1)'(RING) - (RING_W+1)'(r_eff);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign div_start = (state_reg == ST_DIV_START);

    assign ram_wdata = {in_alpha, in_blue, in_green, in_red};
    assign ram_waddr = addr_of(in_ring_reg, in_col_reg);
    assign ram_raddr = addr_of(yring_reg, xx_reg);

    always_comb
    begin
        state_next     = state_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        rad_next       = rad_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_ring_next   = in_ring_reg;
        complete_next  = complete_reg;
        emit_col_next  = emit_col_reg;
        emit_row_next  = emit_row_reg;
        emit_ring_next = emit_ring_reg;
        n_next         = n_reg;
        xx_next        = xx_reg;
        xx0_next       = xx0_reg;
        yring_next     = yring_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        rd_v_next      = (state_reg == ST_READ);
        acc_next       = acc_reg;
        fd_next        = fd_reg;
        pend_v_next    = pend_v_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        pend_q_next    = pend_q_reg;
        pend_fd_next   = pend_fd_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_q_next     = out_q_reg;
        out_fd_next    = out_fd_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        push           = 1'b0;
        push_last      = 1'b0;

        if (rd_v_reg)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                acc_next[c] = acc_reg[c] + SUM_W'(ram_rdata[c*CH_W +: CH_W]);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    unique case (cfg_index)
                        CFG_IDX_WIDTH:  fw_next  = cfg_data;
                        CFG_IDX_HEIGHT: fh_next  = cfg_data;
                        CFG_IDX_RADIUS: rad_next = cfg_data[RAD_W-1:0];
                        default: ;
                    endcase
                    // A valid register write abandons the frame in progress.
                    if (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT ||
                        cfg_index == CFG_IDX_RADIUS)
                    begin
                        in_col_next    = '0;
                        in_row_next    = '0;
                        in_ring_next   = '0;
                        emit_col_next  = '0;
                        emit_row_next  = '0;
                        emit_ring_next = '0;
                        complete_next  = 1'b0;
                    end
                end
                else if (in_fire)
                begin
                    n_next     = '0;
                    state_next = ST_CHECK;
                    // Pixels that arrive while the frame is flushing are dropped.
                    if (action == ACT_PIXEL && !complete_reg)
                    begin
                        ram_we = 1'b1;
                        if ((CW+1)'(in_col_reg) + 1'b1 >= w_eff)
                        begin
                            in_col_next = '0;
                            if (HGT_W'(in_row_reg) + 1'b1 >= h_eff)
                            begin
                                in_row_next   = '0;
                                in_ring_next  = '0;
                                complete_next = 1'b1;
                            end
                            else
                            begin
                                in_row_next  = in_row_reg + 1'b1;
                                in_ring_next = ring_inc(in_ring_reg);
                            end
                        end
                        else
                        begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                    end
                end
            end

            ST_CHECK:
            begin
                if (can_emit)
                begin
                    if (!pend_v_reg || out_free)
                    begin
                        push        = pend_v_reg;
                        pend_v_next = 1'b0;
                        n_next      = n_reg + 1'b1;
                        dx_next     = '0;
                        dy_next     = '0;
                        if ((CW+1)'(emit_col_reg) >= (CW+1)'(r_eff))
                        begin
                            xx_next  = emit_col_reg - CW'(r_eff);
                            xx0_next = emit_col_reg - CW'(r_eff);
                        end
                        else
                        begin
                            xx_next  = '0;
                            xx0_next = '0;
                        end
                        if (HGT_W'(emit_row_reg) >= HGT_W'(r_eff))
                        begin
                            yring_next = ring_back[RING_W-1:0];
                        end
                        else
                        begin
                            yring_next = '0;
                        end
                        for (int c = 0; c < NUM_CH; c++)
                        begin
                            acc_next[c] = '0;
                        end
                        state_next = ST_READ;
                    end
                end
                else if (!pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push        = 1'b1;
                    push_last   = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            ST_READ:
            begin
                ram_re = 1'b1;
                if (dx_reg == r2)
                begin
                    dx_next = '0;
                    xx_next = xx0_reg;
                    if (dy_reg == r2)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        dy_next = dy_reg + 1'b1;
                        if (y_move)
                        begin
                            yring_next = ring_inc(yring_reg);
                        end
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                    if (x_move)
                    begin
                        xx_next = xx_reg + 1'b1;
                    end
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DIV_START;
            end

            ST_DIV_START:
            begin
                fd_next    = ((CW+1)'(emit_col_reg) == wm1) && (HGT_W'(emit_row_reg) == hm1);
                state_next = ST_DIV_RUN;
            end

            ST_DIV_RUN:
            begin
                if (div_done[0])
                begin
                    pend_v_next  = 1'b1;
                    pend_x_next  = POS_W'(emit_col_reg);
                    pend_y_next  = POS_W'(emit_row_reg);
                    pend_fd_next = fd_reg;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        pend_q_next[c] = div_q[c][CH_W-1:0];
                    end
                    if ((CW+1)'(emit_col_reg) + 1'b1 >= w_eff)
                    begin
                        emit_col_next = '0;
                        if (HGT_W'(emit_row_reg) + 1'b1 >= h_eff)
                        begin
                            emit_row_next  = '0;
                            emit_ring_next = '0;
                            complete_next  = 1'b0;
                        end
                        else
                        begin
                            emit_row_next  = emit_row_reg + 1'b1;
                            emit_ring_next = ring_inc(emit_ring_reg);
                        end
                    end
                    else
                    begin
                        emit_col_next = emit_col_reg + 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
            out_x_next     = pend_x_reg;
            out_y_next     = pend_y_reg;
            out_q_next     = pend_q_reg;
            out_fd_next    = pend_fd_reg;
            out_last_next  = push_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fw_reg        <= CFG_DATA_W'(640);
            fh_reg        <= CFG_DATA_W'(480);
            rad_reg       <= RAD_W'(1);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            complete_reg  <= 1'b0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_ring_reg <= '0;
            n_reg         <= '0;
            rd_v_reg      <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            rad_reg       <= rad_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_ring_reg   <= in_ring_next;
            complete_reg  <= complete_next;
            emit_col_reg  <= emit_col_next;
            emit_row_reg  <= emit_row_next;
            emit_ring_reg <= emit_ring_next;
            n_reg         <= n_next;
            rd_v_reg      <= rd_v_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg       <= xx_next;
        xx0_reg      <= xx0_next;
        yring_reg    <= yring_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        acc_reg      <= acc_next;
        fd_reg       <= fd_next;
        pend_x_reg   <= pend_x_next;
        pend_y_reg   <= pend_y_next;
        pend_q_reg   <= pend_q_next;
        pend_fd_reg  <= pend_fd_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_q_reg    <= out_q_next;
        out_fd_reg   <= out_fd_next;
        out_last_reg <= out_last_next;
    end

    bbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_div
        bbr_div #(
            .N_W (SUM_W),
            .D_W (AREA_W)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (acc_reg[g]),
            .divisor  (area),
            .quotient (div_q[g]),
            .done     (div_done[g])
        );
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_red    = out_q_reg[0];
    assign out_green  = out_q_reg[1];
    assign out_blue   = out_q_reg[2];
    assign out_alpha  = out_q_reg[3];
    assign frame_done = out_fd_reg;
    assign last       = out_last_reg;

    `BBR_ASSERT_ALWAYS(a_budget, clk, rst_n, n_reg <= BUDGET_W'(STEP_BUDGET))
    `BBR_ASSERT_ALWAYS(a_in_col, clk, rst_n, (CW+1)'(in_col_reg) < w_eff)
    `BBR_ASSERT_ALWAYS(a_emit_col, clk, rst_n, (CW+1)'(emit_col_reg) < w_eff)
    `BBR_ASSERT_IMPLY(a_push_pend, clk, rst_n, push, pend_v_reg)
    `BBR_ASSERT_NEXT(a_div_end, clk, rst_n, state_reg == ST_DIV_RUN && div_done[0], state_reg == ST_CHECK && pend_v_reg)

endmodule

`default_nettype wire
